// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

    // One input item as it arrives on the input channel.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic [7:0] target_col;
        logic [7:0] target_row;
    } t_in_item;

    // One result item as it leaves on the output channel.
    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [15:0] data;
        logic        last;
    } t_out_item;

    // Work handed from the front to the back through the queue.
    typedef struct packed {
        logic        crt;        // 1: four CRT port writes, 0: one cell write
        logic [15:0] pos;        // linear position row*cols+col
        logic [15:0] cell_word;  // cell word, used only for cell writes
    } t_job;

    // Push side of the queue as seen from the front.
    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    localparam logic [2:0] OP_CHAR  = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_LEFT  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_UP    = 3'd4;
    localparam logic [2:0] OP_DOWN  = 3'd5;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [15:0] CRT_INDEX_PORT = 16'h03D4;
    localparam logic [15:0] CRT_DATA_PORT  = 16'h03D5;
    localparam logic [7:0]  CRT_POS_HIGH   = 8'h0E;
    localparam logic [7:0]  CRT_POS_LOW    = 8'h0F;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_CRT  = 1'b1;

    localparam logic CFG_BACKGROUND = 1'b0;
    localparam logic CFG_FOREGROUND = 1'b1;

    localparam logic [3:0] BG_RESET = 4'd0;
    localparam logic [3:0] FG_RESET = 4'd7;

    localparam int Q_DEPTH = 4;

endpackage

// ===== hw/rtl/tccw_front.sv =====
module tccw_front
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_cfg_we,
    input  logic     i_cfg_index,
    input  logic [3:0] i_cfg_data,
    output t_push    o_push
);

    localparam logic [7:0] COLS8 = 8'(SCREEN_COLS);
    localparam logic [7:0] ROWS8 = 8'(SCREEN_ROWS);

    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic [3:0] r_bg;
    logic [3:0] r_fg;

    logic       is_move;
    logic [7:0] tgt_col;
    logic [7:0] tgt_row;
    logic       in_bounds;
    logic       is_edit;
    logic [7:0] sel_col;
    logic [7:0] sel_row;
    logic [15:0] lin_pos;

    always_comb begin
        is_move = 1'b1;
        tgt_col = r_col;
        tgt_row = r_row;
        case (i_item.op)
            OP_MOVE: begin
                tgt_col = i_item.target_col;
                tgt_row = i_item.target_row;
            end
            OP_LEFT:  tgt_col = r_col - 8'd1;
            OP_RIGHT: tgt_col = r_col + 8'd1;
            OP_UP:    tgt_row = r_row - 8'd1;
            OP_DOWN:  tgt_row = r_row + 8'd1;
            default:  is_move = 1'b0;
        endcase
    end

    assign in_bounds = (tgt_col <= COLS8) && (tgt_row <= ROWS8);

    // Backspace at column zero falls through and is printed as a glyph.
    assign is_edit = (i_item.char_code == CH_BACKSPACE && r_col != 8'd0) ||
                     (i_item.char_code == CH_RETURN) ||
                     (i_item.char_code == CH_NEWLINE);

    assign sel_col = is_move ? tgt_col : r_col;
    assign sel_row = is_move ? tgt_row : r_row;
    assign lin_pos = 16'(COLS8) * 16'(sel_row) + 16'(sel_col);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        o_push.push = 1'b0;
        o_push.job  = '{crt: is_move, pos: lin_pos,
                        cell_word: {r_bg, r_fg, i_item.char_code}};
        if (i_accept) begin
            if (i_item.op == OP_CHAR) begin
                if (i_item.char_code == CH_BACKSPACE && r_col != 8'd0) begin
                    n_col = r_col - 8'd1;
                end else if (i_item.char_code == CH_RETURN) begin
                    n_col = 8'd0;
                end else if (i_item.char_code == CH_NEWLINE) begin
                    n_col = 8'd0;
                    n_row = r_row + 8'd1;
                end else begin
                    n_col = r_col + 8'd1;
                end
                o_push.push = !is_edit;
            end else if (is_move && in_bounds) begin
                n_col       = tgt_col;
                n_row       = tgt_row;
                o_push.push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_bg  <= BG_RESET;
            r_fg  <= FG_RESET;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we && i_cfg_index == CFG_BACKGROUND) begin
                r_bg <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_FOREGROUND) begin
                r_fg <= i_cfg_data;
            end
        end
    end

endmodule

// ===== hw/rtl/tccw_queue.sv =====
module tccw_queue
    import tccw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_nonempty,
    output t_job  o_head
);

    localparam int PW = $clog2(Q_DEPTH);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == (PW+1)'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push.push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tccw_back.sv =====
module tccw_back
    import tccw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_nonempty,
    input  t_job      i_head,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam logic [1:0] BEAT_LAST = 2'd3;

    logic [1:0] r_beat, n_beat;
    logic       r_valid, n_valid;
    t_out_item  r_item, n_item;
    logic       load;

    assign load = !r_valid || !i_out_stall;

    always_comb begin
        n_beat  = r_beat;
        n_valid = r_valid;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_nonempty;
            if (i_nonempty) begin
                if (i_head.crt) begin
                    n_item.kind = KIND_CRT;
                    n_item.last = (r_beat == BEAT_LAST);
                    case (r_beat)
                        2'd0: begin
                            n_item.address = CRT_INDEX_PORT;
                            n_item.data    = {8'd0, CRT_POS_HIGH};
                        end
                        2'd1: begin
                            n_item.address = CRT_DATA_PORT;
                            n_item.data    = {8'd0, i_head.pos[15:8]};
                        end
                        2'd2: begin
                            n_item.address = CRT_INDEX_PORT;
                            n_item.data    = {8'd0, CRT_POS_LOW};
                        end
                        default: begin
                            n_item.address = CRT_DATA_PORT;
                            n_item.data    = {8'd0, i_head.pos[7:0]};
                        end
                    endcase
                    o_pop  = (r_beat == BEAT_LAST);
                    n_beat = r_beat + 2'd1;
                end else begin
                    n_item = '{kind: KIND_CELL, address: i_head.pos,
                               data: i_head.cell_word, last: 1'b1};
                    o_pop  = 1'b1;
                    n_beat = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_beat  <= n_beat;
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// ===== hw/rtl/text_console_cursor_writer.sv =====
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+----------------------------
// input     | in        | i_in_valid / o_in_stall       | i_in_item  (t_in_item)
// output    | out       | o_out_valid / i_out_stall     | o_out_item (t_out_item)
// config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Characters are taken one per cycle unless the job queue is full; a cell write passes
// the queue and the output register. A cursor command gives four CRT port writes in a row.
// The four-entry job queue sets how many commands the input runs ahead of the output.
// Reset is synchronous and active low; it homes the cursor and restores the colors.
// The input stalls only while the job queue is full; the config port is always ready.
module text_console_cursor_writer
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    t_push push;
    logic  q_full;
    logic  q_nonempty;
    t_job  q_head;
    logic  pop;
    logic  in_accept;

    // The config registers can always take a write.
    assign o_cfg_ready = 1'b1;

    // The front needs a free queue slot. Edits that give no result also
    // wait while the queue is full.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // The front owns the cursor, classifies each item, and turns those that
    // produce output into a job carrying the linear position.
    tccw_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_push     (push)
    );

    // The queue lets characters keep flowing while the back is busy with
    // the four port writes of a cursor command.
    tccw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (pop),
        .o_full    (q_full),
        .o_nonempty(q_nonempty),
        .o_head    (q_head)
    );

    // The back expands each job into its result items behind an output
    // register.
    tccw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (q_head),
        .o_pop      (pop),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

endmodule

// ===== hw/rtl/tccw_checker.sv =====
module tccw_checker
    import tccw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    // Output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A cell write is always the only result of its item.
    a_cell_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_CELL |-> o_out_item.last)
        else $error("cell write without last");

    // Index port writes carry a position register index and never close a command.
    a_index_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_CRT &&
        o_out_item.address == CRT_INDEX_PORT |->
        !o_out_item.last &&
        (o_out_item.data == {8'd0, CRT_POS_HIGH} ||
         o_out_item.data == {8'd0, CRT_POS_LOW}))
        else $error("bad CRT index write");

    // A command always ends on the data port.
    a_crt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_CRT && o_out_item.last |->
        o_out_item.address == CRT_DATA_PORT)
        else $error("command ended off the data port");

endmodule

bind text_console_cursor_writer tccw_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
